[sv/owm_pkg.sv]
// Shared types, constants and helper functions of the 1-Wire bus master.
package owm_pkg;

    // Command codes carried by the opcode field.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SMP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_TAIL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ZERO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_SLOT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_LOW     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_SLOT    = 3'd7;

    // Reset values of the timing registers, in microsecond ticks.
    localparam logic [9:0] RESET_LOW_DEFAULT    = 10'd500;
    localparam logic [7:0] PRESENCE_SMP_DEFAULT = 8'd75;
    localparam logic [9:0] RESET_TAIL_DEFAULT   = 10'd430;
    localparam logic [6:0] WRITE_ZERO_DEFAULT   = 7'd60;
    localparam logic [6:0] WRITE_SLOT_DEFAULT   = 7'd61;
    localparam logic [3:0] READ_LOW_DEFAULT     = 4'd3;
    localparam logic [5:0] READ_SAMPLE_DEFAULT  = 6'd14;
    localparam logic [6:0] READ_SLOT_DEFAULT    = 7'd69;

    // Reflected CRC-8 polynomial.
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Bus sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_WRITE    = 3'd4,
        PH_READ     = 3'd5
    } phase_t;

    // Timing configuration as seen by the sequencer.
    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_sample_time;
        logic [9:0] reset_tail_time;
        logic [6:0] write_zero_low_time;
        logic [6:0] write_slot_time;
        logic [3:0] read_low_time;
        logic [5:0] read_sample_time;
        logic [6:0] read_slot_time;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
        logic [7:0] crc_value;
    } res_t;

    // A zero timing value counts as one tick.
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    // One bit step of the reflected CRC-8.
    function automatic logic [7:0] crc8_bit(input logic [7:0] c, input logic b);
        logic [7:0] r;
        r = {1'b0, c[7:1]};
        if (c[0] ^ b)
        begin
            r = r ^ CRC_POLY;
        end
        return r;
    endfunction

endpackage

[sv/onewire_bus_master_core.sv]
// Top level of the 1-Wire bus master: handshakes, configuration and sequencer.
// Each accepted input beat is one microsecond tick and yields one result beat.
// A valid result stands in the output register in the cycle after its input beat is accepted.
// Throughput is one beat per cycle whenever the input is not stalled.
// Input is stalled only while an earlier result waits in the output register.
// Asynchronous active-low reset: idle phase, cleared CRC and status, default timings.
module onewire_bus_master_core
    import owm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [7:0]             tx_byte,
    input  logic                   bus_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   drive_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   presence,
    output logic [7:0]             rx_byte,
    output logic [7:0]             crc_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    res_t res;
    logic step;
    logic out_valid_reg, out_valid_next;

    // An input beat is taken whenever the output register is free or being emptied.
    assign in_stall  = out_valid_reg && out_stall;
    assign step      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    owm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owm_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .opcode  (opcode),
        .tx_byte (tx_byte),
        .bus_in  (bus_in),
        .cfg     (cfg),
        .res     (res)
    );

    // Output valid tracks whether the result register holds an untaken beat.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_low = res.drive_low;
    assign busy_res  = res.busy_res;
    assign done_res  = res.done_res;
    assign presence  = res.presence;
    assign rx_byte   = res.rx_byte;
    assign crc_value = res.crc_value;

    // An accepted beat always leaves a result waiting on the next cycle.
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid
    ) else $error("accepted beat produced no result");

    // Input stalls only behind a waiting result.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid
    ) else $error("input stalled with an empty output register");

    // A finishing tick is always part of an operation.
    a_done_implies_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> busy_res
    ) else $error("done reported outside an operation");

endmodule

[sv/owm_cfg_regs.sv]
// Timing configuration register file of the 1-Wire bus master.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Register writes; each register keeps the low bits of the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= RESET_LOW_DEFAULT;
            cfg_reg.presence_sample_time <= PRESENCE_SMP_DEFAULT;
            cfg_reg.reset_tail_time      <= RESET_TAIL_DEFAULT;
            cfg_reg.write_zero_low_time  <= WRITE_ZERO_DEFAULT;
            cfg_reg.write_slot_time      <= WRITE_SLOT_DEFAULT;
            cfg_reg.read_low_time        <= READ_LOW_DEFAULT;
            cfg_reg.read_sample_time     <= READ_SAMPLE_DEFAULT;
            cfg_reg.read_slot_time       <= READ_SLOT_DEFAULT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RESET_LOW:    cfg_reg.reset_low_time       <= wr_data;
                REG_PRESENCE_SMP: cfg_reg.presence_sample_time <= wr_data[7:0];
                REG_RESET_TAIL:   cfg_reg.reset_tail_time      <= wr_data;
                REG_WRITE_ZERO:   cfg_reg.write_zero_low_time  <= wr_data[6:0];
                REG_WRITE_SLOT:   cfg_reg.write_slot_time      <= wr_data[6:0];
                REG_READ_LOW:     cfg_reg.read_low_time        <= wr_data[3:0];
                REG_READ_SAMPLE:  cfg_reg.read_sample_time     <= wr_data[5:0];
                REG_READ_SLOT:    cfg_reg.read_slot_time       <= wr_data[6:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/owm_engine.sv]
// Tick sequencer of the 1-Wire bus master: slot timing, shifter, CRC and result register.
module owm_engine
    import owm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] opcode,
    input  logic [7:0] tx_byte,
    input  logic       bus_in,
    input  cfg_t       cfg,
    output res_t       res
);

    phase_t     phase_reg, phase_next;
    logic [9:0] tick_count_reg, tick_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] crc_reg, crc_next;
    logic       presence_flag_reg, presence_flag_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    res_t       res_reg, res_next;

    // Working values after a possible command start on this tick.
    phase_t     ph_s;
    logic [9:0] tc_s;
    logic [2:0] bi_s;
    logic [7:0] sb_s;
    logic [7:0] crc_s;
    logic [10:0] tc_inc;
    logic [9:0] low_lim;
    logic [9:0] slot_lim;
    logic [9:0] samp_pt;
    logic       drive;

    // Command start, then one tick of the current phase.
    always_comb
    begin
        ph_s  = (phase_reg inside {PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL,
                                   PH_WRITE, PH_READ}) ? phase_reg : PH_IDLE;
        tc_s  = tick_count_reg;
        bi_s  = bit_index_reg;
        sb_s  = shift_byte_reg;
        crc_s = crc_reg;

        if (ph_s == PH_IDLE && opcode != OP_TICK)
        begin
            tc_s = 10'd0;
            bi_s = 3'd0;
            case (opcode)
                OP_RESET:
                begin
                    ph_s  = PH_RST_LOW;
                    crc_s = 8'd0;
                end
                OP_WRITE:
                begin
                    ph_s = PH_WRITE;
                    sb_s = tx_byte;
                end
                default:
                begin
                    ph_s = PH_READ;
                    sb_s = 8'd0;
                end
            endcase
        end

        tc_inc   = {1'b0, tc_s} + 11'd1;
        low_lim  = 10'd1;
        slot_lim = 10'd1;
        samp_pt  = 10'd0;
        drive    = 1'b0;

        phase_next         = ph_s;
        tick_count_next    = tc_s;
        bit_index_next     = bi_s;
        shift_byte_next    = sb_s;
        crc_next           = crc_s;
        presence_flag_next = presence_flag_reg;
        rx_hold_next       = rx_hold_reg;
        res_next.done_res  = 1'b0;

        case (ph_s)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RST_LOW:
            begin
                drive           = 1'b1;
                tick_count_next = tc_inc[9:0];
                if (tc_inc >= {1'b0, at_least_one(cfg.reset_low_time)})
                begin
                    phase_next      = PH_RST_WAIT;
                    tick_count_next = 10'd0;
                end
            end
            PH_RST_WAIT:
            begin
                if (tc_s >= {2'b00, cfg.presence_sample_time})
                begin
                    presence_flag_next = ~bus_in;
                    phase_next         = PH_RST_TAIL;
                    tick_count_next    = 10'd0;
                end
                else
                begin
                    tick_count_next = tc_inc[9:0];
                end
            end
            PH_RST_TAIL:
            begin
                tick_count_next = tc_inc[9:0];
                if (tc_inc >= {1'b0, at_least_one(cfg.reset_tail_time)})
                begin
                    res_next.done_res = 1'b1;
                    phase_next        = PH_IDLE;
                    tick_count_next   = 10'd0;
                end
            end
            PH_WRITE:
            begin
                // A one is a short low pulse, a zero a long one.
                low_lim  = sb_s[0] ? 10'd1 : at_least_one({3'b000, cfg.write_zero_low_time});
                slot_lim = at_least_one({3'b000, cfg.write_slot_time});
                drive    = (tc_s < low_lim);
                tick_count_next = tc_inc[9:0];
                if (tc_inc >= {1'b0, slot_lim})
                begin
                    tick_count_next = 10'd0;
                    shift_byte_next = {1'b0, sb_s[7:1]};
                    if (bi_s == 3'd7)
                    begin
                        bit_index_next    = 3'd0;
                        res_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        bit_index_next = bi_s + 3'd1;
                    end
                end
            end
            PH_READ:
            begin
                // The sample point is pulled back to the last slot tick when it lies beyond.
                slot_lim = at_least_one({3'b000, cfg.read_slot_time});
                samp_pt  = ({4'b0000, cfg.read_sample_time} < slot_lim)
                           ? {4'b0000, cfg.read_sample_time} : (slot_lim - 10'd1);
                low_lim  = at_least_one({6'b000000, cfg.read_low_time});
                drive    = (tc_s < low_lim);
                if (tc_s == samp_pt)
                begin
                    shift_byte_next = {bus_in, sb_s[7:1]};
                    crc_next        = crc8_bit(crc_s, bus_in);
                end
                tick_count_next = tc_inc[9:0];
                if (tc_inc >= {1'b0, slot_lim})
                begin
                    tick_count_next = 10'd0;
                    if (bi_s == 3'd7)
                    begin
                        bit_index_next    = 3'd0;
                        rx_hold_next      = shift_byte_next;
                        res_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        bit_index_next = bi_s + 3'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res_next.drive_low = drive;
        res_next.busy_res  = (ph_s != PH_IDLE);
        res_next.presence  = presence_flag_next;
        res_next.rx_byte   = rx_hold_next;
        res_next.crc_value = crc_next;
    end

    // Sequencer state advances by one tick per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tick_count_reg    <= 10'd0;
            bit_index_reg     <= 3'd0;
            shift_byte_reg    <= 8'd0;
            crc_reg           <= 8'd0;
            presence_flag_reg <= 1'b0;
            rx_hold_reg       <= 8'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            tick_count_reg    <= tick_count_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            crc_reg           <= crc_next;
            presence_flag_reg <= presence_flag_next;
            rx_hold_reg       <= rx_hold_next;
        end
    end

    // Result register, loaded with the beat produced by this tick.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[tb/tb_onewire_bus_master_core.sv]
// Self-checking testbench of the 1-Wire bus master core: directed table, then random bus traffic.
module tb_onewire_bus_master_core;
    import owm_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int TAIL_ITEMS  = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int TIMING_REGS = 8;
    localparam int ROW_COUNT   = 24;

    // Field widths of the timing registers, in register index order.
    localparam int REG_WIDTH [TIMING_REGS] = '{10, 8, 10, 7, 7, 4, 6, 7};

    localparam res_t QUIET_LINE = '0;

    typedef struct {
        logic [1:0] op;
        logic [7:0] tx;
        logic       bus;
        bit         typed;
        res_t       want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             opcode = OP_TICK;
    logic [7:0]             tx_byte = 8'h00;
    logic                   bus_in = 1'b1;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   drive_low;
    logic                   busy_res;
    logic                   done_res;
    logic                   presence;
    logic [7:0]             rx_byte;
    logic [7:0]             crc_value;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted sequencer state and timing.
    cfg_t        timing;
    phase_t      seq_phase;
    int unsigned tick_cnt;
    int unsigned bit_cnt;
    logic [7:0]  shift_reg;
    logic [7:0]  crc_acc;
    logic [7:0]  rx_hold;
    logic        pres_flag;

    res_t   line_results [$];
    res_t   head_result;
    int     errors = 0;
    int     items_sent = 0;
    int     idle_cycles = 0;
    int     stall_left = 0;
    bit     quiet = 1'b0;

    // Directed rows: defaults after reset, then all timing registers at zero.
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{OP_TICK,  8'h00, 1'b1, 1'b1, QUIET_LINE},
        '{OP_TICK,  8'hFF, 1'b0, 1'b1, QUIET_LINE},
        '{OP_RESET, 8'h00, 1'b1, 1'b1, {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}},
        '{OP_TICK,  8'h00, 1'b0, 1'b1, {1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00}},
        '{OP_WRITE, 8'h00, 1'b1, 1'b1, {1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00}},
        '{OP_WRITE, 8'hFF, 1'b0, 1'b0, QUIET_LINE},
        '{OP_READ,  8'h00, 1'b1, 1'b0, QUIET_LINE},
        '{OP_READ,  8'hFF, 1'b0, 1'b0, QUIET_LINE},
        '{OP_RESET, 8'h00, 1'b1, 1'b0, QUIET_LINE},
        '{OP_READ,  8'h5A, 1'b0, 1'b0, QUIET_LINE},
        '{OP_WRITE, 8'hA5, 1'b1, 1'b0, QUIET_LINE},
        '{OP_READ,  8'h00, 1'b0, 1'b0, QUIET_LINE},
        '{OP_READ,  8'hFF, 1'b1, 1'b0, QUIET_LINE},
        '{OP_READ,  8'h00, 1'b1, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'h3C, 1'b0, 1'b0, QUIET_LINE},
        '{OP_WRITE, 8'hC3, 1'b1, 1'b0, QUIET_LINE},
        '{OP_RESET, 8'h00, 1'b1, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'hFF, 1'b0, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'h00, 1'b0, 1'b0, QUIET_LINE},
        '{OP_READ,  8'h81, 1'b1, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'h7E, 1'b0, 1'b0, QUIET_LINE},
        '{OP_RESET, 8'h00, 1'b0, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'h00, 1'b1, 1'b0, QUIET_LINE},
        '{OP_TICK,  8'hFF, 1'b0, 1'b0, QUIET_LINE}
    };

    onewire_bus_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .tx_byte   (tx_byte),
        .bus_in    (bus_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive_low (drive_low),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .presence  (presence),
        .rx_byte   (rx_byte),
        .crc_value (crc_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A zero timing value still lasts one tick.
    function automatic int unsigned floor_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Advance the predicted sequencer by one microsecond tick.
    task automatic line_step(input logic [1:0] op, input logic [7:0] tx, input logic bus,
                             output res_t r);
        int unsigned lim;
        int unsigned samp;
        logic        fb;
        r = '0;
        if (seq_phase == PH_IDLE && op != OP_TICK)
        begin
            tick_cnt = 0;
            bit_cnt = 0;
            case (op)
                OP_RESET:
                begin
                    seq_phase = PH_RST_LOW;
                    crc_acc = '0;
                end
                OP_WRITE:
                begin
                    seq_phase = PH_WRITE;
                    shift_reg = tx;
                end
                default:
                begin
                    seq_phase = PH_READ;
                    shift_reg = '0;
                end
            endcase
        end
        r.busy_res = (seq_phase != PH_IDLE);
        case (seq_phase)
            PH_RST_LOW:
            begin
                r.drive_low = 1'b1;
                tick_cnt++;
                if (tick_cnt >= floor_one(timing.reset_low_time))
                begin
                    seq_phase = PH_RST_WAIT;
                    tick_cnt = 0;
                end
            end
            PH_RST_WAIT:
            begin
                if (tick_cnt >= timing.presence_sample_time)
                begin
                    pres_flag = ~bus;
                    seq_phase = PH_RST_TAIL;
                    tick_cnt = 0;
                end
                else
                begin
                    tick_cnt++;
                end
            end
            PH_RST_TAIL:
            begin
                tick_cnt++;
                if (tick_cnt >= floor_one(timing.reset_tail_time))
                begin
                    r.done_res = 1'b1;
                    seq_phase = PH_IDLE;
                    tick_cnt = 0;
                end
            end
            PH_WRITE:
            begin
                lim = shift_reg[0] ? 1 : floor_one(timing.write_zero_low_time);
                r.drive_low = (tick_cnt < lim);
                tick_cnt++;
                if (tick_cnt >= floor_one(timing.write_slot_time))
                begin
                    tick_cnt = 0;
                    shift_reg = shift_reg >> 1;
                    if (bit_cnt == 7)
                    begin
                        bit_cnt = 0;
                        r.done_res = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    else
                    begin
                        bit_cnt++;
                    end
                end
            end
            PH_READ:
            begin
                lim = floor_one(timing.read_slot_time);
                // A sample point past the slot end falls back to its last tick.
                samp = (timing.read_sample_time < lim) ? timing.read_sample_time : lim - 1;
                r.drive_low = (tick_cnt < floor_one(timing.read_low_time));
                if (tick_cnt == samp)
                begin
                    shift_reg = {bus, shift_reg[7:1]};
                    fb = crc_acc[0] ^ bus;
                    crc_acc = {1'b0, crc_acc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
                end
                tick_cnt++;
                if (tick_cnt >= lim)
                begin
                    tick_cnt = 0;
                    if (bit_cnt == 7)
                    begin
                        bit_cnt = 0;
                        rx_hold = shift_reg;
                        r.done_res = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    else
                    begin
                        bit_cnt++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.presence = pres_flag;
        r.rx_byte = rx_hold;
        r.crc_value = crc_acc;
    endtask

    // Offer one tick beat and hold it until the core takes it.
    task automatic send_tick(input logic [1:0] op, input logic [7:0] tx, input logic bus,
                             input bit typed, input res_t want);
        res_t pred;
        line_step(op, tx, bus, pred);
        line_results.push_back(typed ? want : pred);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        tx_byte <= tx;
        bus_in <= bus;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Let the core go quiet, then load all eight timing registers.
    task automatic program_timing(input int unsigned vals [TIMING_REGS]);
        logic [CFG_DATA_W-1:0] value;
        logic [CFG_DATA_W-1:0] junk;
        in_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge clk);
        for (int i = 0; i < TIMING_REGS; i++)
        begin
            // Bits above the register width must be dropped by the core.
            value = CFG_DATA_W'(vals[i]);
            junk = CFG_DATA_W'($urandom) << REG_WIDTH[i];
            cfg_valid <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= value | junk;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (CFG_INDEX_W'(i))
                REG_RESET_LOW:    timing.reset_low_time = value[9:0];
                REG_PRESENCE_SMP: timing.presence_sample_time = value[7:0];
                REG_RESET_TAIL:   timing.reset_tail_time = value[9:0];
                REG_WRITE_ZERO:   timing.write_zero_low_time = value[6:0];
                REG_WRITE_SLOT:   timing.write_slot_time = value[6:0];
                REG_READ_LOW:     timing.read_low_time = value[3:0];
                REG_READ_SAMPLE:  timing.read_sample_time = value[5:0];
                default:          timing.read_slot_time = value[6:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // One bus operation from start to done, with stray commands while busy.
    // With echo set, the line returns the running CRC so the byte read clears it.
    task automatic run_op(input logic [1:0] cmd, input bit echo);
        logic [1:0] op;
        repeat ($urandom_range(0, 2))
            send_tick(OP_TICK, 8'($urandom), 1'($urandom), 1'b0, QUIET_LINE);
        send_tick(cmd, 8'($urandom), echo ? crc_acc[0] : 1'($urandom), 1'b0, QUIET_LINE);
        while (seq_phase != PH_IDLE)
        begin
            op = ($urandom_range(0, 3) == 0) ? 2'($urandom) : OP_TICK;
            send_tick(op, 8'($urandom), echo ? crc_acc[0] : 1'($urandom), 1'b0, QUIET_LINE);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            errors++;
        end
    endtask

    // Result checking and random output stalls.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                head_result = line_results.pop_front();
                check_field("drive_low", head_result.drive_low, drive_low);
                check_field("busy_res", head_result.busy_res, busy_res);
                check_field("done_res", head_result.done_res, done_res);
                check_field("presence", head_result.presence, presence);
                check_field("rx_byte", head_result.rx_byte, rx_byte);
                check_field("crc_value", head_result.crc_value, crc_value);
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned vals [TIMING_REGS];
        int          phase_no;
        timing = '{RESET_LOW_DEFAULT, PRESENCE_SMP_DEFAULT, RESET_TAIL_DEFAULT,
                   WRITE_ZERO_DEFAULT, WRITE_SLOT_DEFAULT, READ_LOW_DEFAULT,
                   READ_SAMPLE_DEFAULT, READ_SLOT_DEFAULT};
        seq_phase = PH_IDLE;
        tick_cnt = 0;
        bit_cnt = 0;
        shift_reg = '0;
        crc_acc = '0;
        rx_hold = '0;
        pres_flag = 1'b0;
        phase_no = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: idle ticks at reset timing, then every register at zero.
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            if (i == 2)
            begin
                vals = '{0, 0, 0, 0, 0, 0, 0, 0};
                program_timing(vals);
            end
            send_tick(directed_rows[i].op, directed_rows[i].tx, directed_rows[i].bus,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        // Random operations under a series of short timings, leaving room for the last part.
        while (items_sent < ITEM_TARGET - TAIL_ITEMS)
        begin
            if (phase_no == 0)
            begin
                vals = '{5, 3, 4, 6, 8, 1, 2, 4};
            end
            else if (phase_no == 1)
            begin
                // Zero bits outlast the slot, and the read sample lies past its end.
                vals = '{3, 1, 2, 20, 5, 6, 40, 7};
            end
            else
            begin
                vals = '{$urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(0, 8),
                         $urandom_range(0, 10), $urandom_range(0, 8), $urandom_range(0, 15),
                         $urandom_range(0, 10), $urandom_range(0, 8)};
            end
            program_timing(vals);
            if (phase_no == 0)
            begin
                // Scratchpad read: reset, eight bytes, then the CRC byte that zeroes it.
                run_op(OP_RESET, 1'b0);
                for (int k = 0; k < 9; k++)
                    run_op(OP_READ, k == 8);
            end
            repeat (4)
                run_op(2'($urandom_range(1, 3)), 1'b0);
            phase_no++;
        end

        // Last part: short timings, beats back to back with no idling on either side.
        quiet = 1'b1;
        vals = '{4, 2, 3, 3, 4, 1, 2, 4};
        program_timing(vals);
        run_op(OP_RESET, 1'b0);
        run_op(OP_WRITE, 1'b0);
        run_op(OP_READ, 1'b0);

        in_valid <= 1'b0;
        while (line_results.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
